/* hw/rtl/pnc_pkg.sv */
// pnc_pkg: shared types and constants for the periodic neighbor classifier.
// No dependencies.
`default_nettype none
package pnc_pkg;
  localparam int MAX_PARTICLES_DEF = 64;
  localparam int COORD_W = 20;
  localparam int LIMIT_W = 32;
  localparam int INDEX_W = 6;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_SQ  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_SQ   = 2'd2;

  localparam logic [COORD_W-1:0] BOX_SIZE_RST = 20'd20480;
  localparam logic [LIMIT_W-1:0] NEAR_SQ_RST  = 32'd1468006;
  localparam logic [LIMIT_W-1:0] FAR_SQ_RST   = 32'd2516582;

  localparam logic [KIND_W-1:0] KIND_OTHER  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEX    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EDGE   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREP,
    ST_SCAN,
    ST_EMIT
  } pnc_state_t;

  typedef struct packed {
    logic issue;
    logic clr;
  } pnc_ctl_t;
endpackage
`default_nettype wire

/* hw/rtl/pnc_if.sv */
// pnc_in_if / pnc_out_if: valid-ready channels carrying position and result beats.
// Depends on pnc_pkg.
`default_nettype none
interface pnc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pnc_pkg::COORD_W-1:0] pos_x;
  logic [pnc_pkg::COORD_W-1:0] pos_y;
  logic                        final_particle;
  modport source (output valid, pos_x, pos_y, final_particle, input ready);
  modport sink   (input valid, pos_x, pos_y, final_particle, output ready);
endinterface

interface pnc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pnc_pkg::INDEX_W-1:0] particle_index;
  logic [pnc_pkg::KIND_W-1:0]  particle_kind;
  logic                        last_result;
  modport source (output valid, particle_index, particle_kind, last_result, input ready);
  modport sink   (input valid, particle_index, particle_kind, last_result, output ready);
endinterface
`default_nettype wire

/* hw/rtl/periodic_neighbour_classifier.sv */
// periodic_neighbour_classifier: while in the load state, loads positions one beat per cycle
// into a ring of cells, then classifies each stored particle. Depends on pnc_pkg, pnc_if,
// pnc_cell, pnc_dist. After the final beat: a setup step, then per particle a scan over one
// ring rotation, a pipeline drain and idle check, and an emit step that waits for the output.
// No new positions are accepted until the last result of the set has been emitted.
// Reset (rst_n, synchronous): empty set, registers at defaults; positions are not cleared.
`default_nettype none
module periodic_neighbour_classifier #(
  parameter int MAX_PARTICLES = pnc_pkg::MAX_PARTICLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  pnc_in_if.sink                              in_chan,
  pnc_out_if.source                           out_chan,
  input  wire logic                           cfg_we,
  input  wire logic [pnc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pnc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pnc_pkg::*;

  localparam int CW = $clog2(MAX_PARTICLES + 1);

  // configuration registers
  logic [COORD_W-1:0] box_r;
  logic [LIMIT_W-1:0] near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r  <= BOX_SIZE_RST;
      near_r <= NEAR_SQ_RST;
      far_r  <= FAR_SQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_SIZE: box_r  <= cfg_wdata[COORD_W-1:0];
        CFG_NEAR_SQ:  near_r <= cfg_wdata;
        CFG_FAR_SQ:   far_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control state
  pnc_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;   // particles stored
  logic [CW-1:0] i_r, i_nxt;       // particle under classification
  logic [CW-1:0] j_r, j_nxt;       // neighbor streamed from ring head
  logic [COORD_W-1:0] ref_x_r, ref_y_r, ref_x_nxt, ref_y_nxt;
  logic [COORD_W-1:0] nref_x_r, nref_y_r, nref_x_nxt, nref_y_nxt;  // next particle
  logic out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;

  logic in_acc, store_en, shift_en, dist_busy;
  logic [KIND_W-1:0] kind;
  pnc_ctl_t ctl;

  // ring of cells; cell 0 is the head that feeds the distance unit
  logic [COORD_W-1:0] cx [MAX_PARTICLES];
  logic [COORD_W-1:0] cy [MAX_PARTICLES];

  for (genvar k = 0; k < MAX_PARTICLES; k++) begin : g_cell
    logic [COORD_W-1:0] nx, ny;
    if (k == MAX_PARTICLES - 1) begin : g_tail
      assign nx = cx[0];
      assign ny = cy[0];
    end else begin : g_mid
      assign nx = cx[k+1];
      assign ny = cy[k+1];
    end
    pnc_cell u_cell (
      .clk      (clk),
      .load_en  (store_en && cnt_r == CW'(k)),
      .load_x   (in_chan.pos_x),
      .load_y   (in_chan.pos_y),
      .shift_en (shift_en),
      .wrap     (cnt_r == CW'(k + 1)),
      .head_x   (cx[0]),
      .head_y   (cy[0]),
      .next_x   (nx),
      .next_y   (ny),
      .pos_x    (cx[k]),
      .pos_y    (cy[k])
    );
  end

  pnc_dist u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .ref_x         (ref_x_r),
    .ref_y         (ref_y_r),
    .cand_x        (cx[0]),
    .cand_y        (cy[0]),
    .box_size      (box_r),
    .near_limit_sq (near_r),
    .far_limit_sq  (far_r),
    .kind          (kind),
    .busy          (dist_busy)
  );

  assign in_chan.ready = (st_r == ST_LOAD);
  assign in_acc   = in_chan.valid && in_chan.ready;
  // a full store drops the position
  assign store_en = in_acc && (cnt_r < CW'(MAX_PARTICLES));

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    ref_x_nxt     = ref_x_r;
    ref_y_nxt     = ref_y_r;
    nref_x_nxt    = nref_x_r;
    nref_y_nxt    = nref_y_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_idx_nxt   = out_idx_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    shift_en      = 1'b0;
    ctl           = '0;
    unique case (st_r)
      ST_LOAD: begin
        if (store_en) cnt_nxt = cnt_r + 1'b1;
        if (in_acc && in_chan.final_particle) st_nxt = ST_PREP;
      end
      ST_PREP: begin
        // head holds particle 0
        ref_x_nxt = cx[0];
        ref_y_nxt = cy[0];
        ctl.clr   = 1'b1;
        i_nxt     = '0;
        j_nxt     = '0;
        st_nxt    = ST_SCAN;
      end
      ST_SCAN: begin
        if (j_r < cnt_r) begin
          ctl.issue = (j_r != i_r);
          shift_en  = 1'b1;
          // hold the next particle's position as it passes the head
          if (j_r == i_r + 1'b1) begin
            nref_x_nxt = cx[0];
            nref_y_nxt = cy[0];
          end
          j_nxt = j_r + 1'b1;
        end else if (!dist_busy) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = INDEX_W'(i_r);
          out_kind_nxt  = kind;
          out_last_nxt  = (i_r + 1'b1 == cnt_r);
          ctl.clr       = 1'b1;
          j_nxt         = '0;
          if (i_r + 1'b1 == cnt_r) begin
            cnt_nxt = '0;
            st_nxt  = ST_LOAD;
          end else begin
            i_nxt     = i_r + 1'b1;
            ref_x_nxt = nref_x_r;
            ref_y_nxt = nref_y_r;
            st_nxt    = ST_SCAN;
          end
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ref_x_r    <= ref_x_nxt;
    ref_y_r    <= ref_y_nxt;
    nref_x_r   <= nref_x_nxt;
    nref_y_r   <= nref_y_nxt;
    out_idx_r  <= out_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.particle_index = out_idx_r;
  assign out_chan.particle_kind  = out_kind_r;
  assign out_chan.last_result    = out_last_r;
endmodule
`default_nettype wire

/* hw/rtl/pnc_cell.sv */
// pnc_cell: one ring slot holding a particle position; loads or rotates.
// Depends on pnc_pkg.
`default_nettype none
module pnc_cell (
  input  wire logic                        clk,
  input  wire logic                        load_en,
  input  wire logic [pnc_pkg::COORD_W-1:0] load_x,
  input  wire logic [pnc_pkg::COORD_W-1:0] load_y,
  input  wire logic                        shift_en,
  input  wire logic                        wrap,
  input  wire logic [pnc_pkg::COORD_W-1:0] head_x,
  input  wire logic [pnc_pkg::COORD_W-1:0] head_y,
  input  wire logic [pnc_pkg::COORD_W-1:0] next_x,
  input  wire logic [pnc_pkg::COORD_W-1:0] next_y,
  output logic      [pnc_pkg::COORD_W-1:0] pos_x,
  output logic      [pnc_pkg::COORD_W-1:0] pos_y
);
  import pnc_pkg::*;

  logic [COORD_W-1:0] x_r, y_r, x_nxt, y_nxt;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (load_en) begin
      x_nxt = load_x;
      y_nxt = load_y;
    end else if (shift_en) begin
      x_nxt = wrap ? head_x : next_x;
      y_nxt = wrap ? head_y : next_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign pos_x = x_r;
  assign pos_y = y_r;
endmodule
`default_nettype wire

/* hw/rtl/pnc_dist.sv */
// pnc_dist: pipelined minimum-image distance, shell counters and kind tracking.
// Depends on pnc_pkg.
`default_nettype none
module pnc_dist (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire pnc_pkg::pnc_ctl_t           ctl,
  input  wire logic [pnc_pkg::COORD_W-1:0] ref_x,
  input  wire logic [pnc_pkg::COORD_W-1:0] ref_y,
  input  wire logic [pnc_pkg::COORD_W-1:0] cand_x,
  input  wire logic [pnc_pkg::COORD_W-1:0] cand_y,
  input  wire logic [pnc_pkg::COORD_W-1:0] box_size,
  input  wire logic [pnc_pkg::LIMIT_W-1:0] near_limit_sq,
  input  wire logic [pnc_pkg::LIMIT_W-1:0] far_limit_sq,
  output logic      [pnc_pkg::KIND_W-1:0]  kind,
  output logic                             busy
);
  import pnc_pkg::*;

  localparam int SQ_W  = 2 * COORD_W;
  localparam int SUM_W = SQ_W + 1;

  function automatic logic [COORD_W-1:0] axis_mag(
    input logic [COORD_W-1:0] a,
    input logic [COORD_W-1:0] b,
    input logic [COORD_W-1:0] box
  );
    logic [COORD_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    if ({d, 1'b0} > {1'b0, box}) begin
      d = (d >= box) ? (d - box) : (box - d);
    end
    return d;
  endfunction

  logic               v1_r, v2_r, v3_r;
  logic [COORD_W-1:0] mx_r, my_r;
  logic [SQ_W-1:0]    sx_r, sy_r;
  logic               near_r, far_r;
  logic [CNT_W-1:0]   nc_r, fc_r, nc_nxt, fc_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic [SUM_W-1:0]   sum;

  // stage 1: per-axis magnitude; stage 2: squares; stage 3: sum and compare
  always_ff @(posedge clk) begin
    mx_r <= axis_mag(ref_x, cand_x, box_size);
    my_r <= axis_mag(ref_y, cand_y, box_size);
    sx_r <= mx_r * mx_r;
    sy_r <= my_r * my_r;
    near_r <= sum < SUM_W'(near_limit_sq);
    far_r  <= (sum >= SUM_W'(near_limit_sq)) && (sum < SUM_W'(far_limit_sq));
  end

  assign sum = SUM_W'(sx_r) + SUM_W'(sy_r);

  always_comb begin
    nc_nxt   = nc_r;
    fc_nxt   = fc_r;
    kind_nxt = kind_r;
    if (v3_r) begin
      if (near_r && nc_r != CNT_MAX) nc_nxt = nc_r + 1'b1;
      if (far_r && fc_r != CNT_MAX)  fc_nxt = fc_r + 1'b1;
      priority if (nc_nxt == 6'd6 && fc_nxt == 6'd0) kind_nxt = KIND_HEX;
      else if (nc_nxt == 6'd5 && fc_nxt == 6'd2)     kind_nxt = KIND_EDGE;
      else if (nc_nxt == 6'd4 && fc_nxt == 6'd4)     kind_nxt = KIND_SQUARE;
    end
    if (ctl.clr) begin
      nc_nxt   = '0;
      fc_nxt   = '0;
      kind_nxt = KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      nc_r   <= '0;
      fc_r   <= '0;
      kind_r <= KIND_OTHER;
    end else begin
      v1_r   <= ctl.issue;
      v2_r   <= v1_r;
      v3_r   <= v2_r;
      nc_r   <= nc_nxt;
      fc_r   <= fc_nxt;
      kind_r <= kind_nxt;
    end
  end

  assign kind = kind_r;
  assign busy = v1_r | v2_r | v3_r;
endmodule
`default_nettype wire
